[src/srq_pkg.sv]
package srq_pkg;

    // Default sizes of the queue
    localparam int DEPTH_DEFAULT    = 16;
    localparam int ID_BITS_DEFAULT  = 8;
    localparam int KEY_BITS_DEFAULT = 32;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Request payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  entity_id;
        logic [31:0] run_key;
    } srq_req_t;

    // Response payload
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_id;
        logic [31:0] out_key;
        logic [4:0]  occupancy;
    } srq_rsp_t;

    // Action broadcast to every cell
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_POP,
        ACT_ERASE
    } srq_act_t;

    // Flags handed from one cell to the next one toward the tail
    typedef struct packed {
        logic lt;    // this cell holds a valid key below the new key
        logic seen;  // a matching id was found at or ahead of this cell
    } srq_link_t;

endpackage

[src/sorted_ready_queue.sv]
// Channel  Signals                    Direction  Payload
// request  req_valid, req_stall, req  in         cmd, entity_id, run_key
// response rsp_valid, rsp_stall, rsp  out        status, out_id, out_key, occupancy
//
// Each request is first registered; then every cell of the compare-and-shift
// chain compares and moves its entry at once.
// Requests are taken one at a time; a waiting response does not block the
// next request from being registered, only its execution.
// Reset clears the entry count and the handshake state; entry contents are
// left as they are and never read above the count.
module sorted_ready_queue #(
    parameter int DEPTH    = srq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS  = srq_pkg::ID_BITS_DEFAULT,
    parameter int KEY_BITS = srq_pkg::KEY_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  srq_pkg::srq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output srq_pkg::srq_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    srq_pkg::srq_req_t   req_reg;
    logic                busy_reg;
    logic                rsp_valid_reg;
    srq_pkg::srq_rsp_t   rsp_reg;
    srq_pkg::srq_rsp_t   rsp_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    logic                exec;
    srq_pkg::srq_act_t   act;
    logic [ID_BITS-1:0]  new_id;
    logic [KEY_BITS-1:0] new_key;
    logic                full;
    logic                empty;

    logic [ID_BITS-1:0]  cell_id  [DEPTH];
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [ID_BITS-1:0]  cell_hid [DEPTH];
    logic [KEY_BITS-1:0] cell_hkey[DEPTH];
    srq_pkg::srq_link_t  link     [DEPTH+1];
    logic [ID_BITS-1:0]  hit_id;
    logic [KEY_BITS-1:0] hit_key;

    assign req_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Execute the held request once the response register is free
    assign exec    = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign new_id  = ID_BITS'(req_reg.entity_id);
    assign new_key = KEY_BITS'(req_reg.run_key);
    assign full    = count_reg == CNT_BITS'(DEPTH);
    assign empty   = count_reg == '0;

    // Head of the chain: insert position starts at cell zero, no match yet
    assign link[0].lt   = 1'b1;
    assign link[0].seen = 1'b0;

    // Decide what the cells do
    always_comb
    begin
        act = srq_pkg::ACT_HOLD;
        if (exec)
        begin
            case (req_reg.cmd)
                srq_pkg::CMD_INSERT: act = full ? srq_pkg::ACT_HOLD : srq_pkg::ACT_INSERT;
                srq_pkg::CMD_POP:    act = empty ? srq_pkg::ACT_HOLD : srq_pkg::ACT_POP;
                srq_pkg::CMD_ERASE:  act = srq_pkg::ACT_ERASE;
                default:             act = srq_pkg::ACT_HOLD;
            endcase
        end
    end

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0]  left_id;
        logic [KEY_BITS-1:0] left_key;
        logic [ID_BITS-1:0]  right_id;
        logic [KEY_BITS-1:0] right_key;

        if (i == 0)
        begin : g_head
            assign left_id  = new_id;
            assign left_key = new_key;
        end
        else
        begin : g_mid
            assign left_id  = cell_id[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_id  = cell_id[i];
            assign right_key = cell_key[i];
        end
        else
        begin : g_body
            assign right_id  = cell_id[i+1];
            assign right_key = cell_key[i+1];
        end

        srq_cell #(
            .INDEX    (i),
            .ID_BITS  (ID_BITS),
            .KEY_BITS (KEY_BITS),
            .CNT_BITS (CNT_BITS)
        ) u_cell (
            .clk       (clk),
            .act       (act),
            .count     (count_reg),
            .new_id    (new_id),
            .new_key   (new_key),
            .left_id   (left_id),
            .left_key  (left_key),
            .right_id  (right_id),
            .right_key (right_key),
            .link_in   (link[i]),
            .link_out  (link[i+1]),
            .id        (cell_id[i]),
            .key       (cell_key[i]),
            .hit_id    (cell_hid[i]),
            .hit_key   (cell_hkey[i])
        );
    end

    // Gather the erased entry; at most one cell reports a hit
    always_comb
    begin
        hit_id  = '0;
        hit_key = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            hit_id  = hit_id | cell_hid[j];
            hit_key = hit_key | cell_hkey[j];
        end
    end

    // Form the response and the new count
    always_comb
    begin
        count_next       = count_reg;
        rsp_next.status  = srq_pkg::ST_OK;
        rsp_next.out_id  = '0;
        rsp_next.out_key = '0;
        case (req_reg.cmd)
            srq_pkg::CMD_INSERT:
            begin
                if (full)
                    rsp_next.status = srq_pkg::ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            srq_pkg::CMD_POP:
            begin
                if (empty)
                    rsp_next.status = srq_pkg::ST_EMPTY;
                else
                begin
                    count_next       = count_reg - 1'b1;
                    rsp_next.out_id  = 8'(cell_id[0]);
                    rsp_next.out_key = 32'(cell_key[0]);
                end
            end
            srq_pkg::CMD_ERASE:
            begin
                if (link[DEPTH].seen)
                begin
                    count_next       = count_reg - 1'b1;
                    rsp_next.out_id  = 8'(hit_id);
                    rsp_next.out_key = 32'(hit_key);
                end
                else
                    rsp_next.status = srq_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.occupancy = 5'(count_next);
    end

    // Hold the request until it executes, and register the response
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            req_reg <= req;
        if (exec)
            rsp_reg <= rsp_next;
    end

    // Advance handshake state and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                busy_reg <= 1'b1;
            else if (exec)
                busy_reg <= 1'b0;

            if (exec)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

endmodule

[src/srq_cell.sv]
module srq_cell #(
    parameter int INDEX    = 0,
    parameter int ID_BITS  = srq_pkg::ID_BITS_DEFAULT,
    parameter int KEY_BITS = srq_pkg::KEY_BITS_DEFAULT,
    parameter int CNT_BITS = 5
) (
    input  logic                clk,
    input  srq_pkg::srq_act_t   act,
    input  logic [CNT_BITS-1:0] count,
    input  logic [ID_BITS-1:0]  new_id,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [ID_BITS-1:0]  left_id,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [ID_BITS-1:0]  right_id,
    input  logic [KEY_BITS-1:0] right_key,
    input  srq_pkg::srq_link_t  link_in,
    output srq_pkg::srq_link_t  link_out,
    output logic [ID_BITS-1:0]  id,
    output logic [KEY_BITS-1:0] key,
    output logic [ID_BITS-1:0]  hit_id,
    output logic [KEY_BITS-1:0] hit_key
);

    logic [ID_BITS-1:0]  id_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [ID_BITS-1:0]  id_next;
    logic [KEY_BITS-1:0] key_next;
    logic                valid;
    logic                lt;
    logic                hit;

    // Compare own entry against the request
    always_comb
    begin
        valid         = CNT_BITS'(INDEX) < count;
        lt            = valid && (key_reg < new_key);
        hit           = valid && !link_in.seen && (id_reg == new_id);
        link_out.lt   = lt;
        link_out.seen = link_in.seen || hit;
        hit_id        = hit ? id_reg : '0;
        hit_key       = hit ? key_reg : '0;
    end

    // Pick the next entry: hold, load the new one, or shift from a neighbor
    always_comb
    begin
        id_next  = id_reg;
        key_next = key_reg;
        case (act)
            srq_pkg::ACT_INSERT:
            begin
                if (lt)
                begin
                    id_next  = id_reg;
                    key_next = key_reg;
                end
                else if (link_in.lt)
                begin
                    id_next  = new_id;
                    key_next = new_key;
                end
                else
                begin
                    id_next  = left_id;
                    key_next = left_key;
                end
            end
            srq_pkg::ACT_POP:
            begin
                id_next  = right_id;
                key_next = right_key;
            end
            srq_pkg::ACT_ERASE:
            begin
                if (link_in.seen || hit)
                begin
                    id_next  = right_id;
                    key_next = right_key;
                end
            end
            default:
            begin
                id_next  = id_reg;
                key_next = key_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign id  = id_reg;
    assign key = key_reg;

endmodule
